// ----- hw/rtl/evth_pkg.sv -----
// Package: shared types, constants and the hexahedron corner lists for the volume unit.
package evth_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int VOL_BITS = 60;
	localparam int NUM_TETS = 5;

	typedef struct packed {
		logic [15:0]        element_id;
		logic [2:0]         node_slot;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic [3:0]         nodes_per_element;
		logic               last_node;
	} node_beat_t;

	typedef struct packed {
		logic [15:0]        element_tag;
		logic signed [59:0] six_volume;
		logic               status;
	} result_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EDGE,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_OUT
	} evth_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       store_we;
		logic       fetch;
		logic [2:0] tet_idx;
		logic       is_hex;
		logic       edge_en;
		logic       mul1_en;
		logic       mul2_en;
		logic       acc_clr;
		logic       acc_en;
	} evth_cmd_t;

	// Corner index of tetrahedron t, corner k (0 is apex)
	function automatic logic [2:0] tet_corner(input logic is_hex, input logic [2:0] t,
			input logic [1:0] k);
		logic [2:0] r;
		r = 3'(k);
		if (is_hex) begin
			case (t)
				3'd0: begin
					case (k)
						2'd0: r = 3'd0;
						2'd1: r = 3'd1;
						2'd2: r = 3'd3;
						default: r = 3'd4;
					endcase
				end
				3'd1: begin
					case (k)
						2'd0: r = 3'd1;
						2'd1: r = 3'd4;
						2'd2: r = 3'd5;
						default: r = 3'd6;
					endcase
				end
				3'd2: begin
					case (k)
						2'd0: r = 3'd3;
						2'd1: r = 3'd4;
						2'd2: r = 3'd6;
						default: r = 3'd7;
					endcase
				end
				3'd3: begin
					case (k)
						2'd0: r = 3'd1;
						2'd1: r = 3'd2;
						2'd2: r = 3'd3;
						default: r = 3'd6;
					endcase
				end
				default: begin
					case (k)
						2'd0: r = 3'd1;
						2'd1: r = 3'd4;
						2'd2: r = 3'd6;
						default: r = 3'd3;
					endcase
				end
			endcase
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/evth_ctrl.sv -----
// Controller: sequences corner loads and the per-tetrahedron triple product steps.
module evth_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                in_last,
	input  logic                in_ok,
	input  logic                in_hex,
	input  logic                out_free,
	output logic                in_rdy,
	output logic                out_load,
	output evth_pkg::evth_cmd_t cmd
);

	evth_pkg::evth_state_t state_q, state_d;
	logic [2:0] tet_q, tet_d;
	logic       hex_q, hex_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= evth_pkg::ST_IDLE;
			tet_q   <= 3'd0;
			hex_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			tet_q   <= tet_d;
			hex_q   <= hex_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		tet_d        = tet_q;
		hex_d        = hex_q;
		in_rdy       = 1'b0;
		out_load     = 1'b0;
		cmd          = '0;
		cmd.tet_idx  = tet_q;
		cmd.is_hex   = hex_q;
		case (state_q)
			evth_pkg::ST_IDLE: begin
				in_rdy       = 1'b1;
				cmd.store_we = in_fire;
				cmd.acc_clr  = in_fire;
				if (in_fire && in_last) begin
					if (in_ok) begin
						tet_d   = 3'd0;
						hex_d   = in_hex;
						state_d = evth_pkg::ST_FETCH;
					end else begin
						state_d = evth_pkg::ST_OUT;
					end
				end
			end
			evth_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = evth_pkg::ST_EDGE;
			end
			evth_pkg::ST_EDGE: begin
				cmd.edge_en = 1'b1;
				state_d     = evth_pkg::ST_MUL1;
			end
			evth_pkg::ST_MUL1: begin
				cmd.mul1_en = 1'b1;
				state_d     = evth_pkg::ST_MUL2;
			end
			evth_pkg::ST_MUL2: begin
				cmd.mul2_en = 1'b1;
				state_d     = evth_pkg::ST_ACC;
			end
			evth_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (hex_q && tet_q != 3'(evth_pkg::NUM_TETS - 1)) begin
					tet_d   = tet_q + 3'd1;
					state_d = evth_pkg::ST_FETCH;
				end else begin
					state_d = evth_pkg::ST_OUT;
				end
			end
			evth_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = evth_pkg::ST_IDLE;
				end
			end
			default: state_d = evth_pkg::ST_IDLE;
		endcase
	end

	// Loads only happen while the controller is idle
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_we |-> state_q == evth_pkg::ST_IDLE)
		else $error("store write outside idle");
	// A tetrahedron only has one triple product
	a_tet_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == evth_pkg::ST_ACC && !hex_q) |=> state_q == evth_pkg::ST_OUT)
		else $error("tetrahedron looped");
	// Hex loop index stays in range
	a_tet_range: assert property (@(posedge clk) disable iff (!arst_n)
		tet_q < 3'(evth_pkg::NUM_TETS))
		else $error("tetra index out of range");
	// Result handed over only when output is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result overwrite");

endmodule

// ----- hw/rtl/evth_dp.sv -----
// Datapath: corner store, edge vectors, cofactor and triple product multipliers, accumulator.
module evth_dp #(
	parameter int COORD_BITS = evth_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  evth_pkg::evth_cmd_t                 cmd,
	input  evth_pkg::node_beat_t                node,
	output logic signed [evth_pkg::VOL_BITS-1:0] vol
);

	localparam int CW = COORD_BITS;
	localparam int EW = CW + 1;
	localparam int PW = 2 * EW;
	localparam int FW = PW + 1;
	localparam int TW = FW + EW;

	logic signed [CW-1:0] sx_q [8];
	logic signed [CW-1:0] sy_q [8];
	logic signed [CW-1:0] sz_q [8];

	logic signed [CW-1:0] ax_s1, ay_s1, az_s1;
	logic signed [CW-1:0] bx_s1, by_s1, bz_s1;
	logic signed [CW-1:0] cx_s1, cy_s1, cz_s1;
	logic signed [CW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [EW-1:0] u_s2 [3];
	logic signed [EW-1:0] v_s2 [3];
	logic signed [EW-1:0] w_s2 [3];
	logic signed [FW-1:0] f_s3 [3];
	logic signed [EW-1:0] u_s3 [3];
	logic signed [TW+1:0] t_s4;
	logic signed [evth_pkg::VOL_BITS-1:0] acc_q;

	logic [2:0] ia, ib, ic, id;

	// Corner store write
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			sx_q[node.node_slot] <= CW'(node.coord_x);
			sy_q[node.node_slot] <= CW'(node.coord_y);
			sz_q[node.node_slot] <= CW'(node.coord_z);
		end
	end

	always_comb begin
		ia = evth_pkg::tet_corner(cmd.is_hex, cmd.tet_idx, 2'd0);
		ib = evth_pkg::tet_corner(cmd.is_hex, cmd.tet_idx, 2'd1);
		ic = evth_pkg::tet_corner(cmd.is_hex, cmd.tet_idx, 2'd2);
		id = evth_pkg::tet_corner(cmd.is_hex, cmd.tet_idx, 2'd3);
	end

	// Fetch four corners
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			ax_s1 <= sx_q[ia]; ay_s1 <= sy_q[ia]; az_s1 <= sz_q[ia];
			bx_s1 <= sx_q[ib]; by_s1 <= sy_q[ib]; bz_s1 <= sz_q[ib];
			cx_s1 <= sx_q[ic]; cy_s1 <= sy_q[ic]; cz_s1 <= sz_q[ic];
			dx_s1 <= sx_q[id]; dy_s1 <= sy_q[id]; dz_s1 <= sz_q[id];
		end
	end

	// Edge vectors from the apex
	always_ff @(posedge clk) begin
		if (cmd.edge_en) begin
			u_s2[0] <= EW'(bx_s1) - EW'(ax_s1);
			u_s2[1] <= EW'(by_s1) - EW'(ay_s1);
			u_s2[2] <= EW'(bz_s1) - EW'(az_s1);
			v_s2[0] <= EW'(cx_s1) - EW'(ax_s1);
			v_s2[1] <= EW'(cy_s1) - EW'(ay_s1);
			v_s2[2] <= EW'(cz_s1) - EW'(az_s1);
			w_s2[0] <= EW'(dx_s1) - EW'(ax_s1);
			w_s2[1] <= EW'(dy_s1) - EW'(ay_s1);
			w_s2[2] <= EW'(dz_s1) - EW'(az_s1);
		end
	end

	// Cross product v x w
	always_ff @(posedge clk) begin
		if (cmd.mul1_en) begin
			f_s3[0] <= FW'(v_s2[1] * w_s2[2]) - FW'(v_s2[2] * w_s2[1]);
			f_s3[1] <= FW'(v_s2[2] * w_s2[0]) - FW'(v_s2[0] * w_s2[2]);
			f_s3[2] <= FW'(v_s2[0] * w_s2[1]) - FW'(v_s2[1] * w_s2[0]);
			u_s3    <= u_s2;
		end
	end

	// Dot product with u
	always_ff @(posedge clk) begin
		if (cmd.mul2_en) begin
			t_s4 <= (TW+2)'(u_s3[0] * f_s3[0]) + (TW+2)'(u_s3[1] * f_s3[1])
				+ (TW+2)'(u_s3[2] * f_s3[2]);
		end
	end

	// Accumulate triple products
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + evth_pkg::VOL_BITS'(t_s4);
		end
	end

	assign vol = acc_q;

endmodule

// ----- hw/rtl/element_volume_tet_hex.sv -----
// Top level: element volume unit with config register and registered result.
//  channel  | direction | handshake                  | payload
//  in       | input     | in_valid / in_ready        | node_beat_t
//  out      | output    | out_valid / out_ready      | result_beat_t
//  cfg      | input     | cfg_valid / cfg_ready      | three_d_enable (1 bit)
// A non-last node beat is written into the corner store.
// A last node holds the input while the controller runs fetch, edge, two multiply and accumulate
// steps per triple product (one for a tetrahedron, five for a hexahedron, none for an unsupported
// element) and then hands off to the output register; the shared multiplier chain sets this order.
// Reset clears control and sets enable to 1; corner store is undefined until written.
// A stalled result holds in the output register; the next last node waits in the
// controller until that register frees, and input stalls meanwhile.
module element_volume_tet_hex #(
	parameter int COORD_BITS = evth_pkg::COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  evth_pkg::node_beat_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output evth_pkg::result_beat_t out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	evth_pkg::evth_cmd_t cmd;
	logic        in_rdy, out_load, in_fire, in_ok, in_hex;
	logic        en_q, status_q, out_valid_q;
	logic [15:0] tag_q;
	logic signed [evth_pkg::VOL_BITS-1:0] vol;

	assign cfg_ready = 1'b1;
	assign in_ready  = in_rdy;
	assign in_fire   = in_valid && in_rdy;
	assign in_hex    = in_data.nodes_per_element == 4'd8;
	assign in_ok     = en_q && (in_hex || in_data.nodes_per_element == 4'd4);

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (cfg_valid) begin
			en_q <= cfg_data;
		end
	end

	// Latch tag and status of the last node
	always_ff @(posedge clk) begin
		if (in_fire && in_data.last_node) begin
			tag_q    <= in_data.element_id;
			status_q <= !in_ok;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.element_tag <= tag_q;
			out_data.six_volume  <= status_q ? '0 : vol;
			out_data.status      <= status_q;
		end
	end

	assign out_valid = out_valid_q;

	evth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_last  (in_data.last_node),
		.in_ok    (in_ok),
		.in_hex   (in_hex),
		.out_free (!out_valid_q || out_ready),
		.in_rdy   (in_rdy),
		.out_load (out_load),
		.cmd      (cmd)
	);

	evth_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk  (clk),
		.cmd  (cmd),
		.node (in_data),
		.vol  (vol)
	);

endmodule

// ----- verif/evth_volume_checker.sv -----
// Checker for the element volume unit: watches all channels, predicts results and compares.
module evth_volume_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  evth_pkg::node_beat_t   in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  evth_pkg::result_beat_t out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_data,
	output int                     error_count,
	output int                     pending_count,
	output int                     result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Corner lists of the five tetrahedra that tile a hexahedron
	int hex_list [0:19] = '{0, 1, 3, 4, 1, 4, 5, 6, 3, 4, 6, 7, 1, 2, 3, 6, 1, 4, 6, 3};

	longint corner_x [8];
	longint corner_y [8];
	longint corner_z [8];
	logic mesh_3d;
	evth_pkg::result_beat_t volume_queue [$];

	function automatic longint edge_triple(int a, int b, int c, int d);
		longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
		ux = corner_x[b] - corner_x[a];
		uy = corner_y[b] - corner_y[a];
		uz = corner_z[b] - corner_z[a];
		vx = corner_x[c] - corner_x[a];
		vy = corner_y[c] - corner_y[a];
		vz = corner_z[c] - corner_z[a];
		wx = corner_x[d] - corner_x[a];
		wy = corner_y[d] - corner_y[a];
		wz = corner_z[d] - corner_z[a];
		return ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx) + uz * (vx * wy - vy * wx);
	endfunction

	// Store the corner, and on the last node work out the expected volume
	task automatic predict_volume(input evth_pkg::node_beat_t nb);
		evth_pkg::result_beat_t res;
		longint vol;
		vol = 0;
		corner_x[nb.node_slot] = longint'($signed(nb.coord_x));
		corner_y[nb.node_slot] = longint'($signed(nb.coord_y));
		corner_z[nb.node_slot] = longint'($signed(nb.coord_z));
		if (nb.last_node) begin
			res.element_tag = nb.element_id;
			res.status = 1'b0;
			if (!mesh_3d || (nb.nodes_per_element != 4'd4 && nb.nodes_per_element != 4'd8)) begin
				res.status = 1'b1;
			end else if (nb.nodes_per_element == 4'd4) begin
				vol = edge_triple(0, 1, 2, 3);
			end else begin
				for (int t = 0; t < 5; t++)
					vol += edge_triple(hex_list[4*t], hex_list[4*t+1], hex_list[4*t+2],
						hex_list[4*t+3]);
			end
			res.six_volume = vol[59:0];
			volume_queue.push_back(res);
		end
	endtask

	// Compare one output beat with the oldest expected volume
	task automatic check_volume(input evth_pkg::result_beat_t got);
		evth_pkg::result_beat_t want;
		if (volume_queue.size() == 0) begin
			if (error_count < 10)
				$display("[%0t] unexpected result: tag %h vol %0d status %0b", $realtime,
					got.element_tag, got.six_volume, got.status);
			error_count++;
		end else begin
			want = volume_queue.pop_front();
			if (got.element_tag !== want.element_tag || got.six_volume !== want.six_volume ||
					got.status !== want.status) begin
				if (error_count < 10) begin
					$display("[%0t] mismatch: expected tag %h vol %0d status %0b,",
						$realtime, want.element_tag, want.six_volume, want.status);
					$display("    got tag %h vol %0d status %0b",
						got.element_tag, got.six_volume, got.status);
				end
				error_count++;
			end
		end
	endtask

	// Track every beat on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_3d = 1'b1;
			volume_queue.delete();
			error_count = 0;
			result_count = 0;
			for (int i = 0; i < 8; i++) begin
				corner_x[i] = 0;
				corner_y[i] = 0;
				corner_z[i] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				check_volume(out_data);
				result_count++;
			end
			if (in_valid && in_ready)
				predict_volume(in_data);
			if (cfg_valid && cfg_ready)
				mesh_3d = cfg_data;
		end
		pending_count = volume_queue.size();
	end

endmodule

// ----- verif/tb_element_volume_tet_hex.sv -----
// Testbench top: clock, reset, node stimulus, result sink, watchdog and verdict.
module tb_element_volume_tet_hex;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	evth_pkg::node_beat_t in_data;
	logic out_valid, out_ready;
	evth_pkg::result_beat_t out_data;
	logic cfg_valid, cfg_ready, cfg_data;
	int error_count, pending_count, result_count;
	int node_count;
	int idle_cycles;
	bit burst_mode;
	bit long_hold_done;

	element_volume_tet_hex u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	evth_volume_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.error_count  (error_count),
		.pending_count(pending_count),
		.result_count (result_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [15:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		if (r < 4)
			return 16'($signed($urandom_range(0, 400)) - 200);
		return 16'($urandom);
	endfunction

	// Offer one node beat and hold it until accepted
	task automatic send_node(input logic [15:0] id, input logic [2:0] slot, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input logic [3:0] npe, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = '{id, slot, x, y, z, npe, last};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		node_count++;
		@(negedge clk);
	endtask

	// Send the corners of one element, in a random order half the time, last one flagged
	task automatic send_element(input int kind);
		logic [2:0] order [8];
		logic [15:0] id;
		logic [3:0] npe;
		logic [2:0] tmp;
		int n, j;
		id = 16'($urandom);
		if (kind == 0) begin
			n = 4;
			npe = 4'd4;
		end else if (kind == 1) begin
			n = 8;
			npe = 4'd8;
		end else begin
			n = $urandom_range(1, 8);
			do npe = 4'($urandom); while (npe == 4'd4 || npe == 4'd8);
		end
		for (int i = 0; i < 8; i++)
			order[i] = 3'(i);
		if ($urandom_range(0, 1)) begin
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (int i = 0; i < n; i++)
			send_node(id, order[i], pick_coord(), pick_coord(), pick_coord(), npe, i == n - 1);
	endtask

	// Mostly whole elements, some stray beats
	task automatic run_random(input int target);
		int r;
		while (node_count < target) begin
			burst_mode = ($urandom_range(0, 7) == 0);
			r = $urandom_range(0, 99);
			if (r < 60)
				send_element(0);
			else if (r < 85)
				send_element(1);
			else if (r < 92)
				send_element(2);
			else
				send_node(16'($urandom), 3'($urandom), pick_coord(), pick_coord(), pick_coord(),
					4'($urandom), 1'($urandom));
		end
		in_valid = 1'b0;
	endtask

	task automatic write_mesh_3d(input logic value);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every result is back, then let a last element finish
	task automatic wait_drained();
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Stimulus
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		node_count = 0;
		burst_mode = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_mesh_3d(1'b1);

		// Cube at the coordinate extremes fills every corner
		for (int i = 0; i < 8; i++)
			send_node(16'h0000, 3'(i), i[0] ? 16'h7fff : 16'h8000, i[1] ? 16'h7fff : 16'h8000,
				i[2] ? 16'h7fff : 16'h8000, 4'd8, i == 7);
		// Extreme tetrahedron
		send_node(16'hffff, 3'd0, 16'h8000, 16'h8000, 16'h8000, 4'd4, 1'b0);
		send_node(16'hffff, 3'd1, 16'h7fff, 16'h8000, 16'h8000, 4'd4, 1'b0);
		send_node(16'hffff, 3'd2, 16'h8000, 16'h7fff, 16'h8000, 4'd4, 1'b0);
		send_node(16'hffff, 3'd3, 16'h8000, 16'h8000, 16'h7fff, 4'd4, 1'b1);
		// Stale corners reused by a lone last node
		send_node(16'h1234, 3'd3, 16'h0000, 16'h0000, 16'h0000, 4'd4, 1'b1);
		send_node(16'h4321, 3'd7, 16'h0001, 16'hffff, 16'h0002, 4'd8, 1'b1);
		// Unsupported node counts
		send_node(16'haaaa, 3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 4'd0, 1'b1);
		send_node(16'h5555, 3'd6, 16'h8000, 16'h0000, 16'h7fff, 4'd15, 1'b1);
		send_node(16'h0f0f, 3'd2, 16'h0010, 16'h0020, 16'h0030, 4'd3, 1'b1);
		in_valid = 1'b0;
		wait_drained();

		// Flat mesh: everything unsupported
		write_mesh_3d(1'b0);
		run_random(160);
		wait_drained();

		write_mesh_3d(1'b1);
		run_random(1050);
		wait_drained();

		$display("Sent %0d node beats, checked %0d volume results across 3-D on and off.",
			node_count, result_count);
		if (error_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result sink with random stalls and one long hold-off
	initial begin
		out_ready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && result_count >= 60) begin
				long_hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end else if (burst_mode) begin
				out_ready = 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Watchdog: stop when no beat moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, pending_count);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
